// ===== design/prq_pkg.sv =====
// Shared constants, operation and status codes, and write-enable structs
// for the priority run queue. No dependencies.
package prq_pkg;

  localparam int NUM_LEVELS_DEF = 32;
  localparam int NUM_TASKS_DEF  = 64;

  localparam int OP_W      = 2;
  localparam int TASK_ID_W = 6;
  localparam int LEVEL_W   = 5;
  localparam int STATUS_W  = 2;

  localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_RAISE = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_READY       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_URGENT  = 2'd3;

  // Field write enables of the per-level head/tail memory.
  typedef struct packed {
    logic head;
    logic tail;
  } lvl_wen_t;

  // Field write enables of the per-task link and level memory.
  typedef struct packed {
    logic nxt;
    logic prv;
    logic lvl;
  } task_wen_t;

endpackage

// ===== design/prq_level_mem.sv =====
// Per-level head and tail memory of the run queue, one read and one write
// port, registered read data. Depends on prq_pkg.
module prq_level_mem #(
  parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF,
  parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_LEVELS)-1:0] rd_addr,
  output logic [$clog2(NUM_TASKS)-1:0]  rd_head,
  output logic [$clog2(NUM_TASKS)-1:0]  rd_tail,
  input  logic [$clog2(NUM_LEVELS)-1:0] wr_addr,
  input  prq_pkg::lvl_wen_t             wen,
  input  logic [$clog2(NUM_TASKS)-1:0]  wr_head,
  input  logic [$clog2(NUM_TASKS)-1:0]  wr_tail
);
  import prq_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);

  logic [TW-1:0] head_mem [NUM_LEVELS];
  logic [TW-1:0] tail_mem [NUM_LEVELS];

  always_ff @(posedge clk) begin
    if (wen.head) begin
      head_mem[wr_addr] <= wr_head;
    end
    if (wen.tail) begin
      tail_mem[wr_addr] <= wr_tail;
    end
    if (rd_en) begin
      rd_head <= head_mem[rd_addr];
      rd_tail <= tail_mem[rd_addr];
    end
  end

endmodule

// ===== design/prq_task_mem.sv =====
// Per-task memory of the run queue: next and previous links and recorded
// level, one read and one write port, registered read data. Depends on prq_pkg.
module prq_task_mem #(
  parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF,
  parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_TASKS)-1:0]  rd_addr,
  output logic [$clog2(NUM_TASKS)-1:0]  rd_nxt,
  output logic [$clog2(NUM_TASKS)-1:0]  rd_prv,
  output logic [$clog2(NUM_LEVELS)-1:0] rd_lvl,
  input  logic [$clog2(NUM_TASKS)-1:0]  wr_addr,
  input  prq_pkg::task_wen_t            wen,
  input  logic [$clog2(NUM_TASKS)-1:0]  wr_nxt,
  input  logic [$clog2(NUM_TASKS)-1:0]  wr_prv,
  input  logic [$clog2(NUM_LEVELS)-1:0] wr_lvl
);
  import prq_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);
  localparam int LW = $clog2(NUM_LEVELS);

  logic [TW-1:0]        nxt_mem [NUM_TASKS];
  logic [TW-1:0]        prv_mem [NUM_TASKS];
  logic [LW-1:0]        lvl_mem [NUM_TASKS];
  // A level that was never written reads as zero.
  logic [NUM_TASKS-1:0] lvl_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_vld_r <= '0;
    end else if (wen.lvl) begin
      lvl_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wen.nxt) begin
      nxt_mem[wr_addr] <= wr_nxt;
    end
    if (wen.prv) begin
      prv_mem[wr_addr] <= wr_prv;
    end
    if (wen.lvl) begin
      lvl_mem[wr_addr] <= wr_lvl;
    end
    if (rd_en) begin
      rd_nxt <= nxt_mem[rd_addr];
      rd_prv <= prv_mem[rd_addr];
      rd_lvl <= lvl_vld_r[rd_addr] ? lvl_mem[rd_addr] : '0;
    end
  end

endmodule

// ===== design/priority_run_queue_top.sv =====
// Priority run queue: one linked FIFO per level, lists held in two memories.
// A request walks a short path of sequencer states. An ignored task or an empty dequeue goes straight
// to the output; the others first read and update the two memories, which have registered read data
// and a single write port each. One request at a time: the next is taken the cycle after its result
// enters the output register. Reset (rst_n, synchronous) empties every level.
module priority_run_queue_top #(
  parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF,
  parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [prq_pkg::OP_W-1:0]       in_op,
  input  logic [prq_pkg::TASK_ID_W-1:0]  in_task_id,
  input  logic [prq_pkg::LEVEL_W-1:0]    in_new_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [prq_pkg::STATUS_W-1:0]   out_status,
  output logic [prq_pkg::TASK_ID_W-1:0]  out_chosen_task,
  output logic [prq_pkg::LEVEL_W-1:0]    out_chosen_level
);
  import prq_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);
  localparam int LW = $clog2(NUM_LEVELS);

  // Sequencer states. Each request walks a short path of these; append
  // (AP1/AP2) is shared by enqueue and by a raise of a queued task.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EQ   = 4'd1;
  localparam logic [3:0] S_DQ1  = 4'd2;
  localparam logic [3:0] S_DQ2  = 4'd3;
  localparam logic [3:0] S_RS1  = 4'd4;
  localparam logic [3:0] S_RS2  = 4'd5;
  localparam logic [3:0] S_RS3  = 4'd6;
  localparam logic [3:0] S_AP1  = 4'd7;
  localparam logic [3:0] S_AP2  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;

  // Level occupancy bitmap and per-task ready bits live in flip-flops so
  // that the most urgent level can be found combinationally.
  logic [NUM_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [NUM_TASKS-1:0]  ready_r, ready_nxt;

  // Request context held while the sequencer works on it.
  logic [OP_W-1:0] op_r, op_nxt;
  logic [TW-1:0]   t_r, t_nxt;
  logic [LW-1:0]   lv_r, lv_nxt;
  logic [LW-1:0]   old_r, old_nxt;
  logic [TW-1:0]   nt_r, nt_nxt;
  logic [TW-1:0]   pt_r, pt_nxt;
  logic [TW-1:0]   hd_r, hd_nxt;
  logic [TW-1:0]   tl_r, tl_nxt;
  logic            fix_r, fix_nxt;

  // Result waiting for the output register, and the output register itself.
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [TASK_ID_W-1:0] res_task_r, res_task_nxt;
  logic [LEVEL_W-1:0]   res_level_r, res_level_nxt;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [TASK_ID_W-1:0] out_task_r;
  logic [LEVEL_W-1:0]   out_level_r;

  // Memory ports.
  logic          lm_rd_en;
  logic [LW-1:0] lm_rd_addr;
  logic [TW-1:0] lm_rd_head, lm_rd_tail;
  logic [LW-1:0] lm_wr_addr;
  lvl_wen_t      lm_wen;
  logic [TW-1:0] lm_wr_head, lm_wr_tail;

  logic          tm_rd_en;
  logic [TW-1:0] tm_rd_addr;
  logic [TW-1:0] tm_rd_nxt, tm_rd_prv;
  logic [LW-1:0] tm_rd_lvl;
  logic [TW-1:0] tm_wr_addr;
  task_wen_t     tm_wen;
  logic [TW-1:0] tm_wr_nxt, tm_wr_prv;
  logic [LW-1:0] tm_wr_lvl;

  // Decoded request fields.
  logic [TW-1:0] t_in;
  logic          tvalid_in;
  logic [LW-1:0] lv_in;
  logic [LW-1:0] first_lvl;
  logic          any_ready;
  logic          out_load;

  prq_level_mem #(
    .NUM_LEVELS (NUM_LEVELS),
    .NUM_TASKS  (NUM_TASKS)
  ) u_level_mem (
    .clk     (clk),
    .rd_en   (lm_rd_en),
    .rd_addr (lm_rd_addr),
    .rd_head (lm_rd_head),
    .rd_tail (lm_rd_tail),
    .wr_addr (lm_wr_addr),
    .wen     (lm_wen),
    .wr_head (lm_wr_head),
    .wr_tail (lm_wr_tail)
  );

  prq_task_mem #(
    .NUM_LEVELS (NUM_LEVELS),
    .NUM_TASKS  (NUM_TASKS)
  ) u_task_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tm_rd_en),
    .rd_addr (tm_rd_addr),
    .rd_nxt  (tm_rd_nxt),
    .rd_prv  (tm_rd_prv),
    .rd_lvl  (tm_rd_lvl),
    .wr_addr (tm_wr_addr),
    .wen     (tm_wen),
    .wr_nxt  (tm_wr_nxt),
    .wr_prv  (tm_wr_prv),
    .wr_lvl  (tm_wr_lvl)
  );

  // Task numbers beyond the table are ignored; levels beyond it saturate.
  assign t_in      = TW'(in_task_id);
  assign tvalid_in = (32'(in_task_id) < NUM_TASKS);
  assign lv_in     = (32'(in_new_level) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                        : LW'(in_new_level);

  // Most urgent occupied level: the lowest set bit of the bitmap.
  always_comb begin
    first_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) begin
        first_lvl = LW'(i);
      end
    end
  end
  assign any_ready = |nonempty_r;

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    nonempty_nxt   = nonempty_r;
    ready_nxt      = ready_r;
    op_nxt         = op_r;
    t_nxt          = t_r;
    lv_nxt         = lv_r;
    old_nxt        = old_r;
    nt_nxt         = nt_r;
    pt_nxt         = pt_r;
    hd_nxt         = hd_r;
    tl_nxt         = tl_r;
    fix_nxt        = fix_r;
    res_status_nxt = res_status_r;
    res_task_nxt   = res_task_r;
    res_level_nxt  = res_level_r;

    lm_rd_en   = 1'b0;
    lm_rd_addr = lv_r;
    lm_wr_addr = lv_r;
    lm_wen     = '0;
    lm_wr_head = t_r;
    lm_wr_tail = t_r;
    tm_rd_en   = 1'b0;
    tm_rd_addr = t_r;
    tm_wr_addr = t_r;
    tm_wen     = '0;
    tm_wr_nxt  = t_r;
    tm_wr_prv  = tl_r;
    tm_wr_lvl  = lv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_op;
          t_nxt          = t_in;
          lv_nxt         = lv_in;
          res_status_nxt = ST_OK;
          res_task_nxt   = in_task_id;
          res_level_nxt  = '0;
          unique case (in_op)
            OP_ENQ: begin
              if (tvalid_in) begin
                // Fetch the task's level and the target level's tail together.
                lm_rd_en   = 1'b1;
                lm_rd_addr = lv_in;
                tm_rd_en   = 1'b1;
                tm_rd_addr = t_in;
                state_nxt  = S_EQ;
              end else begin
                state_nxt = S_OUT;
              end
            end
            OP_DEQ: begin
              if (any_ready) begin
                lm_rd_en   = 1'b1;
                lm_rd_addr = first_lvl;
                lv_nxt     = first_lvl;
                state_nxt  = S_DQ1;
              end else begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_OUT;
              end
            end
            OP_RAISE, OP_NOP: begin
              if (tvalid_in) begin
                tm_rd_en   = 1'b1;
                tm_rd_addr = t_in;
                state_nxt  = S_RS1;
              end else begin
                state_nxt = S_OUT;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_EQ: begin
        if (ready_r[t_r]) begin
          res_status_nxt = ST_READY;
          res_level_nxt  = LEVEL_W'(tm_rd_lvl);
          state_nxt      = S_OUT;
        end else begin
          ready_nxt[t_r] = 1'b1;
          state_nxt      = S_AP1;
        end
      end

      S_AP1: begin
        // The level memory still holds the tail of level lv_r.
        if (nonempty_r[lv_r]) begin
          tl_nxt     = lm_rd_tail;
          tm_wr_addr = lm_rd_tail;
          tm_wen.nxt = 1'b1;
          tm_wr_nxt  = t_r;
          state_nxt  = S_AP2;
        end else begin
          lm_wen.head        = 1'b1;
          lm_wen.tail        = 1'b1;
          nonempty_nxt[lv_r] = 1'b1;
          tm_wen.lvl         = 1'b1;
          res_status_nxt     = ST_OK;
          res_level_nxt      = LEVEL_W'(lv_r);
          state_nxt          = S_OUT;
        end
      end

      S_AP2: begin
        tm_wen.prv     = 1'b1;
        tm_wen.lvl     = 1'b1;
        tm_wr_prv      = tl_r;
        lm_wen.tail    = 1'b1;
        res_status_nxt = ST_OK;
        res_level_nxt  = LEVEL_W'(lv_r);
        state_nxt      = S_OUT;
      end

      S_DQ1: begin
        hd_nxt     = lm_rd_head;
        tl_nxt     = lm_rd_tail;
        tm_rd_en   = 1'b1;
        tm_rd_addr = lm_rd_head;
        state_nxt  = S_DQ2;
      end

      S_DQ2: begin
        ready_nxt[hd_r] = 1'b0;
        if (hd_r == tl_r) begin
          nonempty_nxt[lv_r] = 1'b0;
        end else begin
          // The successor becomes head and inherits the old head's back link.
          lm_wen.head = 1'b1;
          lm_wr_head  = tm_rd_nxt;
          tm_wr_addr  = tm_rd_nxt;
          tm_wen.prv  = 1'b1;
          tm_wr_prv   = tm_rd_prv;
        end
        res_status_nxt = ST_OK;
        res_task_nxt   = TASK_ID_W'(hd_r);
        res_level_nxt  = LEVEL_W'(lv_r);
        state_nxt      = S_OUT;
      end

      S_RS1: begin
        if (op_r == OP_NOP) begin
          res_level_nxt = LEVEL_W'(tm_rd_lvl);
          state_nxt     = S_OUT;
        end else if (lv_r >= tm_rd_lvl) begin
          res_status_nxt = ST_NOT_URGENT;
          res_level_nxt  = LEVEL_W'(tm_rd_lvl);
          state_nxt      = S_OUT;
        end else if (!ready_r[t_r]) begin
          tm_wen.lvl    = 1'b1;
          res_level_nxt = LEVEL_W'(lv_r);
          state_nxt     = S_OUT;
        end else begin
          old_nxt    = tm_rd_lvl;
          nt_nxt     = tm_rd_nxt;
          pt_nxt     = tm_rd_prv;
          lm_rd_en   = 1'b1;
          lm_rd_addr = tm_rd_lvl;
          state_nxt  = S_RS2;
        end
      end

      S_RS2: begin
        // Unlink from the old level; the forward fix-up goes out now, the
        // backward one next cycle through the same write port.
        lm_wr_addr = old_r;
        fix_nxt    = 1'b0;
        if ((lm_rd_head == t_r) && (lm_rd_tail == t_r)) begin
          nonempty_nxt[old_r] = 1'b0;
        end else begin
          lm_wen.head = (lm_rd_head == t_r);
          lm_wr_head  = nt_r;
          lm_wen.tail = (lm_rd_tail == t_r);
          lm_wr_tail  = pt_r;
          if (lm_rd_head != t_r) begin
            tm_wr_addr = pt_r;
            tm_wen.nxt = 1'b1;
            tm_wr_nxt  = nt_r;
          end
          fix_nxt = (lm_rd_tail != t_r);
        end
        state_nxt = S_RS3;
      end

      S_RS3: begin
        if (fix_r) begin
          tm_wr_addr = nt_r;
          tm_wen.prv = 1'b1;
          tm_wr_prv  = pt_r;
        end
        lm_rd_en   = 1'b1;
        lm_rd_addr = lv_r;
        state_nxt  = S_AP1;
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nonempty_r  <= '0;
      ready_r     <= '0;
      out_valid_r <= 1'b0;
      fix_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      nonempty_r <= nonempty_nxt;
      ready_r    <= ready_nxt;
      fix_r      <= fix_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    t_r          <= t_nxt;
    lv_r         <= lv_nxt;
    old_r        <= old_nxt;
    nt_r         <= nt_nxt;
    pt_r         <= pt_nxt;
    hd_r         <= hd_nxt;
    tl_r         <= tl_nxt;
    res_status_r <= res_status_nxt;
    res_task_r   <= res_task_nxt;
    res_level_r  <= res_level_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_task_r   <= res_task_r;
      out_level_r  <= res_level_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chosen_task  = out_task_r;
  assign out_chosen_level = out_level_r;

endmodule

// ===== dv/tb_priority_run_queue_top.sv =====
// Self-checking testbench for the priority run queue: directed table then random requests.
// Depends on prq_pkg and priority_run_queue_top from the design folder.
module tb_priority_run_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  localparam int NUM_LEVELS   = NUM_LEVELS_DEF;
  localparam int NUM_TASKS    = NUM_TASKS_DEF;
  localparam int RANDOM_COUNT = 1950;

  // One result of the run queue, as it appears on the out_ channel.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TASK_ID_W-1:0] tid;
    logic [LEVEL_W-1:0]   level;
  } sched_result_t;

  // One row of the directed table. Where typed is set, want is the result
  // read straight off the behaviour; otherwise the predictor supplies it.
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TASK_ID_W-1:0] tid;
    logic [LEVEL_W-1:0]   lvl;
    logic                 typed;
    sched_result_t        want;
  } directed_row_t;

  localparam sched_result_t FROM_PREDICTOR = '0;
  localparam int DIRECTED_ROWS = 25;

  // The directed sequence walks the special cases: an empty dequeue after
  // reset, a no-operation request, a raise that is not more urgent, the
  // extreme tasks and levels, enqueue of a task that is already ready, a
  // raise that moves a ready task, a raise of a task that is not ready, and
  // raises that unlink a task from the middle, the head and a lone entry.
  directed_row_t dir_rows [0:DIRECTED_ROWS-1] = '{
    '{OP_DEQ,   6'd5,  5'd0,  1'b1, '{ST_EMPTY,      6'd5,  5'd0}},
    '{OP_NOP,   6'd63, 5'd17, 1'b1, '{ST_OK,         6'd63, 5'd0}},
    '{OP_RAISE, 6'd10, 5'd0,  1'b1, '{ST_NOT_URGENT, 6'd10, 5'd0}},
    '{OP_ENQ,   6'd0,  5'd31, 1'b1, '{ST_OK,         6'd0,  5'd31}},
    '{OP_ENQ,   6'd63, 5'd31, 1'b1, '{ST_OK,         6'd63, 5'd31}},
    '{OP_ENQ,   6'd0,  5'd5,  1'b1, '{ST_READY,      6'd0,  5'd31}},
    '{OP_ENQ,   6'd21, 5'd0,  1'b1, '{ST_OK,         6'd21, 5'd0}},
    '{OP_ENQ,   6'd42, 5'd0,  1'b1, '{ST_OK,         6'd42, 5'd0}},
    '{OP_RAISE, 6'd63, 5'd31, 1'b1, '{ST_NOT_URGENT, 6'd63, 5'd31}},
    '{OP_RAISE, 6'd63, 5'd0,  1'b1, '{ST_OK,         6'd63, 5'd0}},
    '{OP_DEQ,   6'd9,  5'd4,  1'b1, '{ST_OK,         6'd21, 5'd0}},
    '{OP_DEQ,   6'd9,  5'd4,  1'b1, '{ST_OK,         6'd42, 5'd0}},
    '{OP_DEQ,   6'd9,  5'd4,  1'b1, '{ST_OK,         6'd63, 5'd0}},
    '{OP_DEQ,   6'd9,  5'd4,  1'b1, '{ST_OK,         6'd0,  5'd31}},
    '{OP_DEQ,   6'd42, 5'd31, 1'b1, '{ST_EMPTY,      6'd42, 5'd0}},
    '{OP_RAISE, 6'd0,  5'd12, 1'b1, '{ST_OK,         6'd0,  5'd12}},
    '{OP_NOP,   6'd0,  5'd0,  1'b1, '{ST_OK,         6'd0,  5'd12}},
    '{OP_ENQ,   6'd7,  5'd20, 1'b0, FROM_PREDICTOR},
    '{OP_ENQ,   6'd1,  5'd20, 1'b0, FROM_PREDICTOR},
    '{OP_ENQ,   6'd2,  5'd20, 1'b0, FROM_PREDICTOR},
    '{OP_RAISE, 6'd1,  5'd3,  1'b0, FROM_PREDICTOR},
    '{OP_RAISE, 6'd7,  5'd19, 1'b0, FROM_PREDICTOR},
    '{OP_RAISE, 6'd2,  5'd19, 1'b0, FROM_PREDICTOR},
    '{OP_DEQ,   6'd0,  5'd0,  1'b0, FROM_PREDICTOR},
    '{OP_DEQ,   6'd0,  5'd0,  1'b0, FROM_PREDICTOR}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_op = OP_NOP;
  logic [TASK_ID_W-1:0] in_task_id = '0;
  logic [LEVEL_W-1:0]   in_new_level = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [TASK_ID_W-1:0] out_chosen_task;
  logic [LEVEL_W-1:0]   out_chosen_level;

  priority_run_queue_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_task_id       (in_task_id),
    .in_new_level     (in_new_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_chosen_task  (out_chosen_task),
    .out_chosen_level (out_chosen_level)
  );

  always #5 clk = ~clk;

  // Shadow of the run queue: a busy bit, head and tail per level, and
  // forward and backward links, recorded level and ready bit per task.
  logic                 lvl_busy   [NUM_LEVELS];
  logic [TASK_ID_W-1:0] lvl_first  [NUM_LEVELS];
  logic [TASK_ID_W-1:0] lvl_last   [NUM_LEVELS];
  logic [TASK_ID_W-1:0] link_fwd   [NUM_TASKS];
  logic [TASK_ID_W-1:0] link_back  [NUM_TASKS];
  logic [LEVEL_W-1:0]   tsk_lvl    [NUM_TASKS];
  logic                 tsk_queued [NUM_TASKS];

  // Results still owed by the block, oldest first.
  sched_result_t pending_results [$];
  int            mismatches = 0;
  int            burst_left = 0;
  int            cycle_cnt = 0;
  logic [1:0]    stall_mode = 2'd0;

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Appends a task at the tail of a level's list.
  function automatic void link_at_tail(logic [TASK_ID_W-1:0] tid, logic [LEVEL_W-1:0] lvl);
    if (lvl_busy[lvl]) begin
      link_fwd[lvl_last[lvl]] = tid;
      link_back[tid] = lvl_last[lvl];
    end else begin
      lvl_first[lvl] = tid;
      lvl_busy[lvl] = 1'b1;
    end
    lvl_last[lvl] = tid;
  endfunction

  // Removes a task from anywhere in a level's list; a lone entry empties it.
  function automatic void unlink_from_level(logic [TASK_ID_W-1:0] tid,
                                            logic [LEVEL_W-1:0] lvl);
    if (lvl_first[lvl] == tid && lvl_last[lvl] == tid) begin
      lvl_busy[lvl] = 1'b0;
    end else begin
      if (lvl_first[lvl] == tid) lvl_first[lvl] = link_fwd[tid];
      else link_fwd[link_back[tid]] = link_fwd[tid];
      if (lvl_last[lvl] == tid) lvl_last[lvl] = link_back[tid];
      else link_back[link_fwd[tid]] = link_back[tid];
    end
  endfunction

  // Applies one request to the shadow queue and returns the result it owes.
  function automatic sched_result_t run_queue_apply(logic [OP_W-1:0] op,
                                                    logic [TASK_ID_W-1:0] tid,
                                                    logic [LEVEL_W-1:0] lvl);
    sched_result_t        r;
    logic [TASK_ID_W-1:0] head;
    logic [LEVEL_W-1:0]   old;
    logic                 found;
    r.status = ST_OK;
    r.tid    = tid;
    r.level  = '0;
    found    = 1'b0;
    case (op)
      OP_ENQ: begin
        if (tsk_queued[tid]) begin
          r.status = ST_READY;
          r.level  = tsk_lvl[tid];
        end else begin
          tsk_queued[tid] = 1'b1;
          tsk_lvl[tid] = lvl;
          link_at_tail(tid, lvl);
          r.level = lvl;
        end
      end
      OP_DEQ: begin
        r.status = ST_EMPTY;
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (!found && lvl_busy[i]) begin
            found = 1'b1;
            head = lvl_first[i];
            unlink_from_level(head, LEVEL_W'(i));
            tsk_queued[head] = 1'b0;
            r.status = ST_OK;
            r.tid    = head;
            r.level  = LEVEL_W'(i);
          end
        end
      end
      OP_RAISE: begin
        old = tsk_lvl[tid];
        if (lvl >= old) begin
          r.status = ST_NOT_URGENT;
          r.level  = old;
        end else begin
          tsk_lvl[tid] = lvl;
          if (tsk_queued[tid]) begin
            unlink_from_level(tid, old);
            link_at_tail(tid, lvl);
          end
          r.level = lvl;
        end
      end
      default: begin
        r.level = tsk_lvl[tid];
      end
    endcase
    return r;
  endfunction

  // Finds a task whose ready bit matches, scanning from a random start; falls
  // back to the random start when none matches.
  function automatic logic [TASK_ID_W-1:0] pick_task(logic queued_wanted);
    int                   start;
    logic [TASK_ID_W-1:0] t;
    start = $urandom_range(0, NUM_TASKS - 1);
    pick_task = TASK_ID_W'(start);
    for (int k = NUM_TASKS - 1; k >= 0; k--) begin
      t = TASK_ID_W'((start + k) % NUM_TASKS);
      if (tsk_queued[t] == queued_wanted) pick_task = t;
    end
  endfunction

  // Presents one request and holds it until accepted. Requests come in
  // bursts of random length; most bursts are preceded by a gap of idle cycles,
  // some run straight on so that back-to-back stretches occur too.
  task automatic send_request(logic [OP_W-1:0] op, logic [TASK_ID_W-1:0] tid,
                              logic [LEVEL_W-1:0] lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_task_id   <= tid;
    in_new_level <= lvl;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stimulus: reset, the directed table, then the random requests.
  initial begin
    sched_result_t        res;
    logic [OP_W-1:0]      op;
    logic [TASK_ID_W-1:0] tid;
    logic [LEVEL_W-1:0]   lvl;
    int                   r;
    logic                 filling;
    int                   phase_left;

    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_busy[i]  = 1'b0;
      lvl_first[i] = '0;
      lvl_last[i]  = '0;
    end
    for (int i = 0; i < NUM_TASKS; i++) begin
      link_fwd[i]   = '0;
      link_back[i]  = '0;
      tsk_lvl[i]    = '0;
      tsk_queued[i] = 1'b0;
    end
    filling    = 1'b1;
    phase_left = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The predictor runs on every row so that its state keeps step with the
    // block; a typed row is checked against its typed value instead.
    foreach (dir_rows[i]) begin
      res = run_queue_apply(dir_rows[i].op, dir_rows[i].tid, dir_rows[i].lvl);
      pending_results.push_back(dir_rows[i].typed ? dir_rows[i].want : res);
      send_request(dir_rows[i].op, dir_rows[i].tid, dir_rows[i].lvl);
    end

    // Random part. Fill phases lean on enqueue so that lists grow long, drain
    // phases lean on dequeue so that levels empty again. Most requests are
    // well formed (enqueue of an idle task, raise to a more urgent level);
    // the rest hit already-ready tasks and raises that are not more urgent.
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(30, 200);
      end
      phase_left--;
      r   = $urandom_range(0, 99);
      tid = TASK_ID_W'($urandom_range(0, NUM_TASKS - 1));
      lvl = ($urandom_range(0, 9) < 6) ? LEVEL_W'($urandom_range(0, 3))
                                       : LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
      if (r < (filling ? 55 : 15)) begin
        op = OP_ENQ;
        if ($urandom_range(0, 99) < 85) tid = pick_task(1'b0);
      end else if (r < (filling ? 70 : 65)) begin
        op = OP_DEQ;
      end else if (r < (filling ? 92 : 90)) begin
        op = OP_RAISE;
        if ($urandom_range(0, 99) < 80) tid = pick_task(1'b1);
        if (tsk_lvl[tid] != '0 && $urandom_range(0, 99) < 85)
          lvl = LEVEL_W'($urandom_range(0, tsk_lvl[tid] - 1));
      end else begin
        op = OP_NOP;
      end
      pending_results.push_back(run_queue_apply(op, tid, lvl));
      send_request(op, tid, lvl);
    end
    in_valid <= 1'b0;

    // Wait for the last result, then a few cycles more to catch any stray one.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS priority_run_queue_top");
    end else begin
      $display("FAIL priority_run_queue_top");
    end
    $finish;
  end

  // Receiver: the stall pattern is redrawn periodically among always ready,
  // random ready, ready on a short regular period, and long stalls. Each accepted
  // result is compared field by field with the oldest pending one.
  always @(posedge clk) begin : result_check
    sched_result_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 200 == 0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 9) < 6);
      2'd2: out_ready <= (cycle_cnt % 4 == 0);
      default: out_ready <= (cycle_cnt % 32 < 4);
    endcase
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with nothing pending: status %0d task %0d level %0d",
                               out_status, out_chosen_task, out_chosen_level));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_error($sformatf("status %0d, wanted %0d", out_status, want.status));
        if (out_chosen_task !== want.tid)
          report_error($sformatf("chosen task %0d, wanted %0d", out_chosen_task, want.tid));
        if (out_chosen_level !== want.level)
          report_error($sformatf("chosen level %0d, wanted %0d",
                                 out_chosen_level, want.level));
      end
    end
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL priority_run_queue_top");
    $finish;
  end

endmodule
